@@ hw/rtl/ufsr_pkg.sv @@
package ufsr_pkg;

    localparam int unsigned CFG_STAGES = 4;
    localparam int unsigned FREQ_W     = 16;
    localparam int unsigned ROCOF_W    = 16;
    localparam int unsigned RTHR_W     = 15;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned MASK_W     = 4;

    localparam logic [FREQ_W:0] ARM_HYST_MHZ   = 17'd20;
    localparam logic [FREQ_W:0] RESET_HYST_MHZ = 17'd600;

    localparam logic [CFG_STAGES-1:0][FREQ_W-1:0] THR_RESET = {
        16'd48000, 16'd48400, 16'd48700, 16'd49000
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THR_0,
        REG_THR_1,
        REG_THR_2,
        REG_THR_3,
        REG_ARM_DELAY,
        REG_ROCOF_THR,
        REG_ROCOF_EN
    } cfg_reg_t;

    typedef struct packed {
        logic [CFG_STAGES-1:0][FREQ_W-1:0] threshold;
        logic [FREQ_W-1:0]                 arm_delay;
        logic [RTHR_W-1:0]                 rocof_threshold;
        logic                              rocof_enable;
    } cfg_t;

    typedef struct packed {
        logic shed;
        logic restore;
        logic armed;
        logic tripped;
    } stage_status_t;

endpackage

@@ hw/rtl/ufsr_cfg.sv @@
module ufsr_cfg
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [ufsr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ufsr_pkg::CFG_DATA_W-1:0]     cfg_data,
    output ufsr_pkg::cfg_t                      cfg
);
    import ufsr_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_THR_0:     cfg_next.threshold[0] = cfg_data;
                REG_THR_1:     cfg_next.threshold[1] = cfg_data;
                REG_THR_2:     cfg_next.threshold[2] = cfg_data;
                REG_THR_3:     cfg_next.threshold[3] = cfg_data;
                REG_ARM_DELAY: cfg_next.arm_delay = cfg_data;
                REG_ROCOF_THR: cfg_next.rocof_threshold = cfg_data[RTHR_W-1:0];
                REG_ROCOF_EN:  cfg_next.rocof_enable = cfg_data[0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold       <= THR_RESET;
            cfg_reg.arm_delay       <= '0;
            cfg_reg.rocof_threshold <= '0;
            cfg_reg.rocof_enable    <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ hw/rtl/ufsr_stage.sv @@
module ufsr_stage
#(
    parameter int unsigned DELAY_BITS = 16
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            advance,
    input  logic [ufsr_pkg::FREQ_W-1:0]     freq,
    input  logic [ufsr_pkg::FREQ_W-1:0]     threshold,
    input  logic                            rate_ok,
    input  logic [DELAY_BITS-1:0]           delay_load,
    output ufsr_pkg::stage_status_t         status
);
    import ufsr_pkg::*;

    logic                  armed_reg;
    logic                  armed_next;
    logic                  tripped_reg;
    logic                  tripped_next;
    logic [DELAY_BITS-1:0] delay_reg;
    logic [DELAY_BITS-1:0] delay_next;
    logic [DELAY_BITS-1:0] delay_dec;
    logic [FREQ_W:0]       freq_ext;
    logic [FREQ_W:0]       thr_ext;
    logic                  cond;
    logic                  trip_now;

    assign freq_ext  = {1'b0, freq};
    assign thr_ext   = {1'b0, threshold};
    assign delay_dec = (armed_reg && (delay_reg != '0)) ? delay_reg - 1'b1 : delay_reg;
    assign cond      = !tripped_reg && (freq <= threshold) && rate_ok;

    always_comb
    begin
        armed_next   = armed_reg;
        tripped_next = tripped_reg;
        delay_next   = delay_dec;
        trip_now     = 1'b0;
        status       = '0;
        if (cond)
        begin
            armed_next = 1'b1;
            if (!armed_reg)
            begin
                delay_next = delay_load;
            end
            if (delay_next == '0)
            begin
                trip_now     = 1'b1;
                tripped_next = 1'b1;
                armed_next   = 1'b0;
            end
        end
        else if (freq_ext > thr_ext + ARM_HYST_MHZ)
        begin
            armed_next = 1'b0;
        end
        if (tripped_next && (freq_ext > thr_ext + RESET_HYST_MHZ))
        begin
            tripped_next   = 1'b0;
            status.restore = 1'b1;
        end
        status.shed    = trip_now;
        status.armed   = armed_next;
        status.tripped = tripped_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg   <= 1'b0;
            tripped_reg <= 1'b0;
            delay_reg   <= '0;
        end
        else if (advance)
        begin
            armed_reg   <= armed_next;
            tripped_reg <= tripped_next;
            delay_reg   <= delay_next;
        end
    end

endmodule

@@ hw/rtl/under_frequency_shed_relay_core.sv @@
// Each input passes the input register, then the result register; all stages evaluate in parallel in one pass.
// Throughput: one transaction per cycle while out_stall does not hold a waiting result.
// Output register decouples the sides: while a result waits, an empty input register still takes input.
// Reset (rst_n, async, active low): stages disarmed and untripped, delays zero,
// thresholds 49000/48700/48400/48000 mHz, valid flags and other config zero; data registers not reset.
module under_frequency_shed_relay_core
#(
    parameter int unsigned NUM_STAGES = 4,
    parameter int unsigned DELAY_BITS = 16
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [ufsr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ufsr_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [ufsr_pkg::FREQ_W-1:0]         frequency_mhz,
    input  logic signed [ufsr_pkg::ROCOF_W-1:0] rocof_mhz_per_s,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [ufsr_pkg::MASK_W-1:0]         shed_mask,
    output logic [ufsr_pkg::MASK_W-1:0]         restore_mask,
    output logic [ufsr_pkg::MASK_W-1:0]         armed_mask,
    output logic [ufsr_pkg::MASK_W-1:0]         tripped_mask
);
    import ufsr_pkg::*;

    cfg_t                       cfg;
    logic                       in_valid_reg;
    logic                       in_valid_next;
    logic [FREQ_W-1:0]          freq_reg;
    logic signed [ROCOF_W-1:0]  rocof_reg;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [MASK_W-1:0]          shed_reg;
    logic [MASK_W-1:0]          restore_reg;
    logic [MASK_W-1:0]          armed_reg;
    logic [MASK_W-1:0]          tripped_reg;
    logic [MASK_W-1:0]          shed_next;
    logic [MASK_W-1:0]          restore_next;
    logic [MASK_W-1:0]          armed_next;
    logic [MASK_W-1:0]          tripped_next;
    logic                       advance;
    logic                       rate_ok;
    logic [DELAY_BITS-1:0]      delay_load;
    stage_status_t              status [NUM_STAGES];

    ufsr_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // handshake
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (!in_stall)
        begin
            in_valid_next = in_valid;
        end
        out_valid_next = out_valid_reg && out_stall;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall)
        begin
            freq_reg  <= frequency_mhz;
            rocof_reg <= rocof_mhz_per_s;
        end
        if (advance)
        begin
            shed_reg    <= shed_next;
            restore_reg <= restore_next;
            armed_reg   <= armed_next;
            tripped_reg <= tripped_next;
        end
    end

    // rate check: rocof <= -rocof_threshold, or always ok when rocof_enable is low
    assign rate_ok = !cfg.rocof_enable ||
                     ($signed({rocof_reg[ROCOF_W-1], rocof_reg}) <=
                      -$signed({2'b00, cfg.rocof_threshold}));

    generate
        if (DELAY_BITS > FREQ_W)
        begin : g_delay_ext
            assign delay_load = {{(DELAY_BITS-FREQ_W){1'b0}}, cfg.arm_delay};
        end
        else
        begin : g_delay_trunc
            assign delay_load = cfg.arm_delay[DELAY_BITS-1:0];
        end
    endgenerate

    genvar s;
    generate
        for (s = 0; s < NUM_STAGES; s++)
        begin : g_stage
            logic [FREQ_W-1:0] stage_thr;
            if (s < CFG_STAGES)
            begin : g_thr_cfg
                assign stage_thr = cfg.threshold[s];
            end
            else
            begin : g_thr_zero
                assign stage_thr = '0;
            end

            ufsr_stage #(.DELAY_BITS(DELAY_BITS)) u_stage
            (
                .clk        (clk),
                .rst_n      (rst_n),
                .advance    (advance),
                .freq       (freq_reg),
                .threshold  (stage_thr),
                .rate_ok    (rate_ok),
                .delay_load (delay_load),
                .status     (status[s])
            );
        end

        for (s = 0; s < MASK_W; s++)
        begin : g_mask
            if (s < NUM_STAGES)
            begin : g_used
                assign shed_next[s]    = status[s].shed;
                assign restore_next[s] = status[s].restore;
                assign armed_next[s]   = status[s].armed;
                assign tripped_next[s] = status[s].tripped;
            end
            else
            begin : g_unused
                assign shed_next[s]    = 1'b0;
                assign restore_next[s] = 1'b0;
                assign armed_next[s]   = 1'b0;
                assign tripped_next[s] = 1'b0;
            end
        end
    endgenerate

    assign out_valid    = out_valid_reg;
    assign shed_mask    = shed_reg;
    assign restore_mask = restore_reg;
    assign armed_mask   = armed_reg;
    assign tripped_mask = tripped_reg;

`ifndef SYNTHESIS
    a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled while result path free");

    a_armed_not_tripped: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((armed_mask & tripped_mask) == '0))
        else $error("stage both armed and tripped");

    a_shed_accounted: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((shed_mask & ~tripped_mask & ~restore_mask) == '0))
        else $error("shed stage neither tripped nor restored");

    a_restore_clears: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((restore_mask & (tripped_mask | armed_mask)) == '0))
        else $error("restored stage still tripped or armed");
`endif

endmodule

@@ tb/tb_top.sv @@
module tb_top;

    import ufsr_pkg::*;

    localparam int unsigned IDLE_LIMIT = 2000;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef struct packed {
        logic [MASK_W-1:0] shed;
        logic [MASK_W-1:0] restore;
        logic [MASK_W-1:0] armed;
        logic [MASK_W-1:0] tripped;
    } relay_masks_t;

    class relay_scoreboard;
        cfg_t                settings;
        logic [MASK_W-1:0]   armed;
        logic [MASK_W-1:0]   tripped;
        logic [15:0]         delay_left [CFG_STAGES];
        relay_masks_t        expected_q [$];
        int unsigned         errors;
        int unsigned         ticks;
        int unsigned         checked;
        int unsigned         trips;
        int unsigned         recoveries;

        function new();
            settings.threshold       = THR_RESET;
            settings.arm_delay       = '0;
            settings.rocof_threshold = '0;
            settings.rocof_enable    = 1'b0;
            armed   = '0;
            tripped = '0;
            foreach (delay_left[s])
                delay_left[s] = '0;
            errors = 0;
            ticks = 0;
            checked = 0;
            trips = 0;
            recoveries = 0;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function void note_tick(logic [FREQ_W-1:0] freq, logic signed [ROCOF_W-1:0] rocof);
            relay_masks_t m;
            logic         rate_ok;
            int unsigned  thr;
            m = '0;
            rate_ok = !settings.rocof_enable ||
                      (int'(rocof) <= -int'(settings.rocof_threshold));
            for (int s = 0; s < CFG_STAGES; s++)
            begin
                thr = settings.threshold[s];
                if (armed[s] && delay_left[s] != 0)
                    delay_left[s] = delay_left[s] - 1'b1;
                if (!tripped[s] && freq <= thr && rate_ok)
                begin
                    if (!armed[s])
                    begin
                        armed[s] = 1'b1;
                        delay_left[s] = settings.arm_delay;
                    end
                    if (delay_left[s] == 0)
                    begin
                        tripped[s] = 1'b1;
                        armed[s] = 1'b0;
                        m.shed[s] = 1'b1;
                    end
                end
                else if (freq > thr + ARM_HYST_MHZ)
                    armed[s] = 1'b0;
                if (tripped[s] && freq > thr + RESET_HYST_MHZ)
                begin
                    tripped[s] = 1'b0;
                    m.restore[s] = 1'b1;
                end
            end
            m.armed = armed;
            m.tripped = tripped;
            ticks++;
            if (m.shed != 0)
                trips++;
            if (m.restore != 0)
                recoveries++;
            expected_q = {expected_q, m};
        endfunction

        function void compare_field(string name, logic [MASK_W-1:0] exp, logic [MASK_W-1:0] act);
            if (exp !== act)
            begin
                $display("%0t %s mismatch: expected %b, got %b", $time, name, exp, act);
                errors++;
            end
        endfunction

        function void check_result(relay_masks_t act);
            relay_masks_t exp;
            if (expected_q.size() == 0)
            begin
                $display("%0t unexpected result: expected none, got %h", $time, act);
                errors++;
                return;
            end
            exp = expected_q.pop_front();
            checked++;
            compare_field("shed_mask", exp.shed, act.shed);
            compare_field("restore_mask", exp.restore, act.restore);
            compare_field("armed_mask", exp.armed, act.armed);
            compare_field("tripped_mask", exp.tripped, act.tripped);
        endfunction
    endclass

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index = '0;
    logic [CFG_DATA_W-1:0]      cfg_data = '0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic [FREQ_W-1:0]          frequency_mhz = '0;
    logic signed [ROCOF_W-1:0]  rocof_mhz_per_s = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic [MASK_W-1:0]          shed_mask;
    logic [MASK_W-1:0]          restore_mask;
    logic [MASK_W-1:0]          armed_mask;
    logic [MASK_W-1:0]          tripped_mask;

    relay_scoreboard sb;
    logic            calm = 1'b0;
    int unsigned     stall_left = 0;
    int unsigned     idle_cycles = 0;
    int unsigned     settings_used = 0;
    int              walk_f;
    int              walk_lo;
    int              walk_hi;
    logic            falling = 1'b1;

    under_frequency_shed_relay_core u_dut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .frequency_mhz   (frequency_mhz),
        .rocof_mhz_per_s (rocof_mhz_per_s),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .shed_mask       (shed_mask),
        .restore_mask    (restore_mask),
        .armed_mask      (armed_mask),
        .tripped_mask    (tripped_mask)
    );

    always #1 clk = ~clk;

    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n || calm)
        begin
            out_stall <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left != 0)
        begin
            out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else
        begin
            out_stall <= 1'b0;
            stall_left <= gap_len();
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.check_result({shed_mask, restore_mask, armed_mask, tripped_mask});
            if (in_valid && !in_stall)
                sb.note_tick(frequency_mhz, rocof_mhz_per_s);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write || !rst_n)
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t watchdog: no transaction for %0d cycles", $time, IDLE_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic send_tick(input int freq, input int rocof);
        int unsigned gap;
        if (freq < 0)
            freq = 0;
        if (freq > 65535)
            freq = 65535;
        if (rocof < -32768)
            rocof = -32768;
        if (rocof > 32767)
            rocof = 32767;
        in_valid <= 1'b1;
        frequency_mhz <= freq[FREQ_W-1:0];
        rocof_mhz_per_s <= rocof[ROCOF_W-1:0];
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        gap = calm ? 0 : gap_len();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
        repeat (3) @(posedge clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    task automatic load_settings(input cfg_t c, input logic poke_unused);
        wait_idle();
        put_reg(REG_THR_0, c.threshold[0]);
        put_reg(REG_THR_1, c.threshold[1]);
        put_reg(REG_THR_2, c.threshold[2]);
        put_reg(REG_THR_3, c.threshold[3]);
        put_reg(REG_ARM_DELAY, c.arm_delay);
        put_reg(REG_ROCOF_THR, {1'b0, c.rocof_threshold});
        put_reg(REG_ROCOF_EN, {15'd0, c.rocof_enable});
        if (poke_unused)
            put_reg(REG_UNUSED, 16'($urandom));
        cfg_write <= 1'b0;
        sb.settings = c;
        settings_used++;
    endtask

    task automatic random_settings(output cfg_t c, output int base);
        int unsigned r;
        base = $urandom_range(40000, 60000);
        for (int s = 0; s < CFG_STAGES; s++)
        begin
            if ($urandom_range(0, 4) == 0)
                c.threshold[s] = 16'($urandom);
            else
                c.threshold[s] = 16'(base - s * $urandom_range(100, 400));
        end
        r = $urandom_range(0, 99);
        if (r < 15)
            c.arm_delay = '0;
        else if (r < 90)
            c.arm_delay = 16'($urandom_range(1, 8));
        else
            c.arm_delay = 16'($urandom_range(9, 40));
        r = $urandom_range(0, 99);
        if (r < 20)
            c.rocof_threshold = '0;
        else if (r < 25)
            c.rocof_threshold = 15'h7fff;
        else
            c.rocof_threshold = 15'($urandom_range(0, 3000));
        c.rocof_enable = 1'($urandom);
    endtask

    task automatic random_tick();
        int unsigned r;
        int          freq;
        int          rocof;
        int          rthr;
        int unsigned step;
        rthr = sb.settings.rocof_threshold;
        r = $urandom_range(0, 99);
        if (r < 70)
        begin
            if (walk_f <= walk_lo)
                falling = 1'b0;
            else if (walk_f >= walk_hi)
                falling = 1'b1;
            else if ($urandom_range(0, 19) == 0)
                falling = !falling;
            step = $urandom_range(0, 250);
            walk_f = falling ? walk_f - int'(step) : walk_f + int'(step);
            if (walk_f < 0)
                walk_f = 0;
            if (walk_f > 65535)
                walk_f = 65535;
            freq = walk_f;
            if (falling)
                rocof = -int'($urandom_range(0, 2 * rthr + 200));
            else
                rocof = int'($urandom_range(0, 4000)) - 2000;
        end
        else if (r < 90)
        begin
            freq = sb.settings.threshold[$urandom_range(0, CFG_STAGES - 1)];
            case ($urandom_range(0, 6))
                0: freq = freq + 20;
                1: freq = freq + 21;
                2: freq = freq + 600;
                3: freq = freq + 601;
                4: freq = freq - 1;
                5: freq = freq + int'($urandom_range(0, 60)) - 30;
                default: ;
            endcase
            case ($urandom_range(0, 2))
                0: rocof = -rthr;
                1: rocof = -rthr + 1;
                default: rocof = int'($urandom_range(0, 65535)) - 32768;
            endcase
        end
        else
        begin
            freq = $urandom_range(0, 65535);
            rocof = int'($urandom_range(0, 65535)) - 32768;
        end
        send_tick(freq, rocof);
    endtask

    initial
    begin
        cfg_t c;
        int   base;
        sb = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        c.threshold = THR_RESET;
        c.arm_delay = '0;
        c.rocof_threshold = '0;
        c.rocof_enable = 1'b0;
        load_settings(c, 1'b0);
        send_tick(65535, 32767);
        send_tick(49000, 0);
        send_tick(49020, 0);
        send_tick(49601, 0);
        send_tick(0, -32768);
        send_tick(65535, 0);

        c.threshold[0] = 16'hffff;
        c.threshold[1] = 16'd0;
        c.threshold[2] = 16'd65000;
        c.threshold[3] = 16'd1;
        c.arm_delay = 16'd2;
        c.rocof_threshold = 15'h7fff;
        c.rocof_enable = 1'b1;
        load_settings(c, 1'b0);
        send_tick(0, -32768);
        send_tick(0, 0);
        send_tick(0, -32767);
        send_tick(65535, 0);
        send_tick(30, -32768);
        send_tick(21, 0);
        send_tick(22, 0);

        c.threshold = THR_RESET;
        c.arm_delay = 16'hffff;
        c.rocof_threshold = '0;
        c.rocof_enable = 1'b0;
        load_settings(c, 1'b1);
        send_tick(40000, -1);
        send_tick(40000, 1);
        send_tick(65535, 0);

        for (int p = 0; p < 8; p++)
        begin
            random_settings(c, base);
            load_settings(c, p == 3);
            walk_lo = base - 1600;
            walk_hi = base + 900;
            walk_f = base + 500;
            calm = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < 66; i++)
                random_tick();
            calm = 1'b0;
        end

        wait_idle();
        if (sb.pending() != 0)
        begin
            $display("%0t %0d results never arrived", $time, sb.pending());
            sb.errors++;
        end
        $display("relay run: %0d ticks under %0d register settings, %0d results checked",
                 sb.ticks, settings_used, sb.checked);
        $display("ticks with stage trips: %0d, with recoveries: %0d", sb.trips, sb.recoveries);
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
